/* sv/mdio_mm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_mm_pkg
// Types and constants shared by the MDIO management master.
// ----------------------------------------------------------------------------
package mdio_mm_pkg;

	// Command codes carried in the input tuser field.
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	// Configuration register indexes.
	localparam logic REG_PREAMBLE = 1'b0;
	localparam logic REG_HALF     = 1'b1;

	localparam int unsigned MAX_PREAMBLE = 32;
	localparam int unsigned FRAME_BITS   = 32;
	// Frame position of the first turnaround bit and of the first data bit.
	localparam int unsigned TA_POS       = 14;
	localparam int unsigned DATA_POS     = 16;

	localparam logic [5:0] PREAMBLE_RESET = 6'd32;
	localparam logic [7:0] HALF_RESET     = 8'd2;

	// Clause 22 codes placed at the head of the frame.
	localparam logic [1:0] ST_CODE    = 2'b01;
	localparam logic [1:0] OP_READ    = 2'b10;
	localparam logic [1:0] OP_WRITE   = 2'b01;
	localparam logic [1:0] TA_WRITE   = 2'b10;

	// One result item.
	typedef struct packed {
		logic        rejected;
		logic        read_done;
		logic [15:0] read_data;
		logic        busy_res;
		logic        mdio_oe;
		logic        mdio_out;
		logic        mdc;
	} result_t;

endpackage

/* sv/mdio_management_master_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_management_master_top
// Clause 22 MDIO management master driven by a stream of ticks.
// ----------------------------------------------------------------------------
// Every input transaction is one tick of the management clock divider. A tick
// whose command is a read or a write, arriving while no frame is running,
// starts a frame: preamble ones (count set by preamble_bits, capped at 32),
// start code 01, opcode, PHY address, register address, turnaround and 16
// data bits, MSB first. Each bit spends half_period_ticks ticks with MDC low
// and as many with MDC high. A read releases MDIO from the first turnaround
// bit on and samples mdio_in at each rising MDC edge of the data bits; the
// captured word appears in read_data, and read_done marks the tick on which
// the frame ends. A start that arrives while a frame runs is dropped and
// flagged by rejected. Every tick yields exactly one result transaction that
// shows the pin levels after that tick. The block takes one tick per clock
// cycle while the output buffer has room: the whole state update is one short
// step of logic from the state registers into the result register, and a
// two-entry output buffer lets the input side take one more tick after the
// output side stalls. Configuration writes are taken at any time and act at once.
// ----------------------------------------------------------------------------
module mdio_management_master_top
	import mdio_mm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input ticks.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // phy_addr[4:0], reg_addr[9:5], write_data[25:10],
	                               // mdio_in[26], zero fill
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // mdc[0], mdio_out[1], mdio_oe[2], busy_res[3],
	                               // read_data[19:4], read_done[20], rejected[21], zero fill
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	// Configuration registers.
	logic [5:0]  preamble_q;
	logic [7:0]  half_q;

	// Frame state.
	logic        busy_q;
	logic        is_read_q;
	logic [6:0]  bit_q;
	logic [7:0]  tick_q;
	logic        clk_lvl_q;
	logic [31:0] frame_q;
	logic [15:0] capture_q;

	// Output buffer: main register and skid entry.
	result_t     out_q;
	logic        out_valid_q;
	result_t     skid_q;
	logic        skid_valid_q;

	// Next-state values.
	logic        busy_d;
	logic        is_read_d;
	logic [6:0]  bit_d;
	logic [7:0]  tick_d;
	logic        clk_lvl_d;
	logic [31:0] frame_d;
	logic [15:0] capture_d;
	result_t     res;

	logic        in_acc;
	logic        out_take;
	logic        main_free;
	cmd_t        cmd;
	logic [4:0]  phy_addr;
	logic [4:0]  reg_addr;
	logic [15:0] write_data;
	logic        mdio_in;
	logic        start;
	logic [6:0]  eff_pre;
	logic [7:0]  eff_half;
	logic [7:0]  tick_inc;
	logic [6:0]  k_cur;
	logic [6:0]  k_nxt;
	logic [6:0]  frame_end;

	assign cfg_ready = 1'b1;

	assign cmd        = cmd_t'(s_tuser);
	assign phy_addr   = s_tdata[4:0];
	assign reg_addr   = s_tdata[9:5];
	assign write_data = s_tdata[25:10];
	assign mdio_in    = s_tdata[26];
	assign start      = (cmd == CMD_READ) || (cmd == CMD_WRITE);

	assign in_acc    = s_tvalid && s_tready;
	assign out_take  = m_tvalid && m_tready;
	assign main_free = !out_valid_q || out_take;
	assign s_tready  = !skid_valid_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q};

	// A preamble longer than the cap saturates; a zero half period acts as one.
	assign eff_pre   = (preamble_q > 6'(MAX_PREAMBLE)) ? 7'(MAX_PREAMBLE) : {1'b0, preamble_q};
	assign eff_half  = (half_q == 8'd0) ? 8'd1 : half_q;
	assign tick_inc  = tick_q + 8'd1;
	assign k_cur     = bit_q - eff_pre;
	assign frame_end = eff_pre + 7'(FRAME_BITS);

	always_comb begin
		busy_d    = busy_q;
		is_read_d = is_read_q;
		bit_d     = bit_q;
		tick_d    = tick_q;
		clk_lvl_d = clk_lvl_q;
		frame_d   = frame_q;
		capture_d = capture_q;
		res       = '0;

		if (busy_q) begin
			res.rejected = start;
			tick_d = tick_inc;
			if (tick_inc >= eff_half) begin
				tick_d = 8'd0;
				if (!clk_lvl_q) begin
					// Rising MDC edge: a read samples the data bits here.
					clk_lvl_d = 1'b1;
					if (is_read_q && (bit_q >= eff_pre) && (k_cur >= 7'(DATA_POS))
							&& (k_cur < 7'(FRAME_BITS))) begin
						capture_d = {capture_q[14:0], mdio_in};
					end
				end else begin
					// Falling MDC edge: move on to the next bit.
					clk_lvl_d = 1'b0;
					bit_d = bit_q + 7'd1;
					if ((bit_q + 7'd1) >= frame_end) begin
						busy_d = 1'b0;
						res.read_done = is_read_q;
					end
				end
			end
		end else if (start) begin
			is_read_d = (cmd == CMD_READ);
			frame_d = '0;
			frame_d[31:30] = ST_CODE;
			frame_d[29:28] = (cmd == CMD_READ) ? OP_READ : OP_WRITE;
			frame_d[27:23] = phy_addr;
			frame_d[22:18] = reg_addr;
			if (cmd != CMD_READ) begin
				frame_d[17:16] = TA_WRITE;
				frame_d[15:0]  = write_data;
			end
			busy_d    = 1'b1;
			bit_d     = 7'd0;
			tick_d    = 8'd0;
			clk_lvl_d = 1'b0;
		end

		if (!busy_d) begin
			clk_lvl_d = 1'b0;
		end

		// MDIO for the bit now on the wire; idle and out-of-frame bits drive high.
		k_nxt = bit_d - eff_pre;
		res.mdio_out = 1'b1;
		res.mdio_oe  = 1'b1;
		if (busy_d && (bit_d >= eff_pre) && (k_nxt < 7'(FRAME_BITS))) begin
			res.mdio_out = frame_d[~k_nxt[4:0]];
			if (is_read_d && (k_nxt >= 7'(TA_POS))) begin
				res.mdio_out = 1'b0;
				res.mdio_oe  = 1'b0;
			end
		end
		res.mdc       = busy_d && clk_lvl_d;
		res.busy_res  = busy_d;
		res.read_data = capture_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PREAMBLE_RESET;
			half_q     <= HALF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PREAMBLE: preamble_q <= cfg_data[5:0];
				REG_HALF:     half_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			is_read_q <= 1'b0;
			bit_q     <= '0;
			tick_q    <= '0;
			clk_lvl_q <= 1'b0;
			frame_q   <= '0;
			capture_q <= '0;
		end else if (in_acc) begin
			busy_q    <= busy_d;
			is_read_q <= is_read_d;
			bit_q     <= bit_d;
			tick_q    <= tick_d;
			clk_lvl_q <= clk_lvl_d;
			frame_q   <= frame_d;
			capture_q <= capture_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (main_free) begin
				out_valid_q <= skid_valid_q || in_acc;
			end
			if (skid_valid_q) begin
				if (main_free) begin
					skid_valid_q <= 1'b0;
				end
			end else if (in_acc && !main_free) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (!skid_valid_q && in_acc && !main_free) begin
			skid_q <= res;
		end
	end

`ifndef ASSERT_OFF
	// The skid entry only fills behind a held main entry.
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid while main entry empty");

	// MDC rests low whenever no frame runs.
	a_idle_mdc_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !clk_lvl_q)
		else $error("MDC high while idle");

	// A frame that completes is no longer busy in the same result.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.read_done) |-> !out_q.busy_res)
		else $error("read_done reported while busy");

	// A start taken while idle makes the block busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !busy_q && start) |=> busy_q)
		else $error("start accepted but frame not begun");
`endif

endmodule
